// ===== rtl/core/cfft_pkg.sv =====
// Shared constants, twiddle tables and arithmetic helpers of the complex FFT core.
`default_nettype none
package cfft_pkg;

  localparam int MaxPoints  = 1024;
  localparam int LgMax      = 10;
  localparam int AddrBits   = 10;
  localparam int TwIdxBits  = AddrBits - 1;
  localparam int SampleBits = 16;
  localparam int WorkBits   = 28;
  localparam int GuardBits  = 2;
  localparam int TwBits     = 17;
  localparam int ScaleBits  = 15;
  localparam int ProdBits   = TwBits + WorkBits;
  localparam int OutPBits   = WorkBits + ScaleBits + 1;
  localparam int RamWidth   = 2 * WorkBits;

  localparam logic [1:0] CfgSizeLog2 = 2'd0;
  localparam logic [1:0] CfgNegExp   = 2'd1;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef logic signed [TwBits-1:0] tw_t;
  typedef tw_t tw_tab_t [MaxPoints/2];

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned Q30One = 64'd1 << 30;

  function automatic longint q30_to_q15(longint v);
    longint r;
    r = v;
    if (r < 0) r = 0;
    if (r > longint'(Q30One)) r = longint'(Q30One);
    return (r + 64'sd16384) >>> 15;
  endfunction

  // shift-and-subtract quotient for the table build; dividends stay below 2^40
  function automatic longint unsigned div_u40(longint unsigned num, longint unsigned den);
    longint unsigned q, rem;
    q = 0;
    rem = 0;
    for (int b = 39; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 Taylor series over the first quadrant, mirrored into the second
  function automatic tw_tab_t build_tab(bit want_sin);
    tw_tab_t tab;
    longint unsigned kk, ang, x2, ts, tc, dv_s, dv_c;
    longint ss, sc, c, s;
    for (int k = 0; k < MaxPoints/2; k++) begin
      kk = (4 * k <= MaxPoints) ? longint'(k) : longint'(MaxPoints/2 - k);
      ang = (2 * PiQ30 * kk + MaxPoints/2) / MaxPoints;
      x2 = (ang * ang) >> 30;
      ts = ang;
      tc = Q30One;
      ss = 0;
      sc = 0;
      for (int n = 0; n < 14; n++) begin
        if (n % 2 == 1) begin
          ss = ss - longint'(ts);
          sc = sc - longint'(tc);
        end else begin
          ss = ss + longint'(ts);
          sc = sc + longint'(tc);
        end
        dv_s = longint'((2 * n + 2) * (2 * n + 3));
        dv_c = longint'((2 * n + 1) * (2 * n + 2));
        ts = div_u40((ts * x2) >> 30, dv_s);
        tc = div_u40((tc * x2) >> 30, dv_c);
      end
      c = q30_to_q15(sc);
      s = q30_to_q15(ss);
      if (want_sin) tab[k] = TwBits'(s);
      else          tab[k] = (kk == longint'(k)) ? TwBits'(c) : TwBits'(-c);
    end
    return tab;
  endfunction

  localparam tw_tab_t CosTab = build_tab(1'b0);
  localparam tw_tab_t SinTab = build_tab(1'b1);

  // round(32768/sqrt(N)) as the transform defines it
  function automatic logic [ScaleBits-1:0] scale_of(logic [3:0] lg);
    logic [ScaleBits-1:0] c;
    case (lg)
      4'd1:    c = 15'd23170;
      4'd2:    c = 15'd16384;
      4'd3:    c = 15'd11585;
      4'd4:    c = 15'd8192;
      4'd5:    c = 15'd5793;
      4'd6:    c = 15'd4096;
      4'd7:    c = 15'd2896;
      4'd8:    c = 15'd2048;
      4'd9:    c = 15'd1448;
      default: c = 15'd1024;
    endcase
    return c;
  endfunction

  function automatic logic signed [WorkBits-1:0] sat_work(logic signed [31:0] v);
    logic signed [31:0] hi, lo;
    hi = (32'sd1 <<< (WorkBits - 1)) - 32'sd1;
    lo = -(32'sd1 <<< (WorkBits - 1));
    if (v > hi) return WorkBits'(hi);
    if (v < lo) return WorkBits'(lo);
    return WorkBits'(v);
  endfunction

  function automatic logic signed [SampleBits-1:0] sat_out(logic signed [OutPBits-1:0] p);
    logic signed [OutPBits-1:0] r;
    r = (p + (OutPBits'(1) <<< (ScaleBits + GuardBits - 1))) >>> (ScaleBits + GuardBits);
    if (r > OutPBits'(32767)) return 16'sh7fff;
    if (r < -OutPBits'(32768)) return 16'sh8000;
    return SampleBits'(r);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cfft_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module cfft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/complex_fft_radix2_unitary_core.sv =====
// In-place radix-2 DIT complex FFT with unitary output scaling, one shared butterfly.
//
// Slave stream: tuser is the function (0 load a sample, 1 read a bin), tdata the
// sample (re low, im high). Loads fill the work RAM in natural order; the load
// that completes N = 2^size_log2 samples starts the transform. The block then
// drops tready while it runs a bit-reversal pass and log2(N) stages of N/2
// butterflies, all through the one RAM port pair. While idle it takes one load
// per cycle. A read word gives its bin on the master stream (re, im, bin index;
// tlast on bin N-1) through the RAM read, product and output registers; tready
// stays low until that bin is in the output register. Reads while no frame is
// complete are taken and give nothing. A load during read-out abandons the
// remaining bins. A stalled receiver holds the bin in the output register;
// loads are still taken meanwhile, reads wait for it to drain.
// Reset clears counts and state; RAM contents are undefined until loaded.
// Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i.
`default_nettype none
module complex_fft_radix2_unitary_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // sample_re, sample_im
  input  wire logic        s_axis_tuser_i,  // func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // result_re, result_im, bin_index, zero pad
  output logic             m_axis_tlast_o   // last_result
);
  import cfft_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REV  = 3'd1;
  localparam logic [2:0] ST_BFLY = 3'd2;
  localparam logic [2:0] ST_RD1  = 3'd3;
  localparam logic [2:0] ST_RD2  = 3'd4;

  logic [3:0]  size_q;
  logic        negexp_q;
  logic [10:0] load_cnt_q, rd_cnt_q;
  logic        rdy_q;
  logic [2:0]  state_q, ph_q;
  logic [AddrBits-1:0] cnt_q;
  logic [3:0]  stage_q;
  logic [RamWidth-1:0] xa_q;
  logic signed [WorkBits-1:0] xb_re_q, xb_im_q, a_re_q, a_im_q;
  tw_t wr_q, wi_q;
  logic signed [ProdBits-1:0] p1_q, p2_q;
  logic signed [30:0] tr_q, ti_q;
  logic [ScaleBits-1:0] c_q;
  logic last_q;
  logic [AddrBits-1:0] bin_q;
  logic signed [OutPBits-1:0] pr_re_q, pr_im_q;
  logic m_valid_q, m_last_q;
  logic [47:0] m_data_q;

  logic [3:0]  eff_l;
  logic [10:0] n_m1;
  logic        s_acc;
  logic [AddrBits-1:0] rv, rev_j, mask, bf_i, bf_j, tw_full;
  logic [TwIdxBits-1:0] tw_idx;
  logic signed [ProdBits:0] sd, ss;
  logic signed [31:0] dif_re, dif_im, sum_re, sum_im;
  logic signed [WorkBits-1:0] ld_re, ld_im, rd_re, rd_im;
  logic ram_we;
  logic [AddrBits-1:0] ram_waddr, ram_raddr;
  logic [RamWidth-1:0] ram_wdata, ram_rdata;

  always_comb begin
    if (size_q == 4'd0) eff_l = 4'd1;
    else if (size_q > 4'(LgMax)) eff_l = 4'(LgMax);
    else eff_l = size_q;
  end
  assign n_m1 = (11'd1 << eff_l) - 11'd1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    for (int k = 0; k < AddrBits; k++) rv[k] = cnt_q[AddrBits-1-k];
  end
  assign rev_j  = rv >> (4'(AddrBits) - eff_l);
  assign mask   = (AddrBits'(1) << stage_q) - AddrBits'(1);
  assign bf_i   = ((cnt_q & ~mask) << 1) | (cnt_q & mask);
  assign bf_j   = bf_i | (AddrBits'(1) << stage_q);
  assign tw_full = (cnt_q & mask) << (4'(TwIdxBits) - stage_q);
  assign tw_idx = tw_full[TwIdxBits-1:0];

  assign sd = p1_q - p2_q;
  assign ss = p1_q + p2_q;
  assign dif_re = a_re_q - tr_q;
  assign dif_im = a_im_q - ti_q;
  assign sum_re = a_re_q + tr_q;
  assign sum_im = a_im_q + ti_q;

  assign ld_re = WorkBits'(signed'(s_axis_tdata_i[15:0])) <<< GuardBits;
  assign ld_im = WorkBits'(signed'(s_axis_tdata_i[31:16])) <<< GuardBits;
  assign rd_re = ram_rdata[WorkBits-1:0];
  assign rd_im = ram_rdata[RamWidth-1:WorkBits];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = xa_q;
    ram_raddr = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc && s_axis_tuser_i == FuncLoad) begin
          ram_we    = 1'b1;
          ram_waddr = load_cnt_q[AddrBits-1:0];
          ram_wdata = {ld_im, ld_re};
        end
        ram_raddr = rd_cnt_q[AddrBits-1:0];
      end
      ST_REV: begin
        if (ph_q == 3'd1) ram_raddr = rev_j;
        if (ph_q == 3'd2) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
        if (ph_q == 3'd3) begin
          ram_we    = 1'b1;
          ram_waddr = rev_j;
        end
      end
      ST_BFLY: begin
        ram_raddr = (ph_q == 3'd0) ? bf_j : bf_i;
        if (ph_q == 3'd5) begin
          ram_we    = 1'b1;
          ram_waddr = bf_j;
          ram_wdata = {sat_work(dif_im), sat_work(dif_re)};
        end
        if (ph_q == 3'd6) begin
          ram_we    = 1'b1;
          ram_waddr = bf_i;
          ram_wdata = {sat_work(sum_im), sat_work(sum_re)};
        end
      end
      default: ;
    endcase
  end

  cfft_ram #(.Width(RamWidth), .Depth(MaxPoints)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_REV && ph_q == 3'd1) xa_q <= ram_rdata;
    if (state_q == ST_BFLY) begin
      case (ph_q)
        3'd1: begin
          xb_re_q <= rd_re;
          xb_im_q <= rd_im;
          wr_q    <= CosTab[tw_idx];
          wi_q    <= negexp_q ? -SinTab[tw_idx] : SinTab[tw_idx];
        end
        3'd2: begin
          a_re_q <= rd_re;
          a_im_q <= rd_im;
          p1_q   <= wr_q * xb_re_q;
          p2_q   <= wi_q * xb_im_q;
        end
        3'd3: begin
          tr_q <= 31'((sd + (ProdBits+1)'(16384)) >>> 15);
          p1_q <= wr_q * xb_im_q;
          p2_q <= wi_q * xb_re_q;
        end
        3'd4: ti_q <= 31'((ss + (ProdBits+1)'(16384)) >>> 15);
        default: ;
      endcase
    end
    if (state_q == ST_RD1) begin
      pr_re_q <= rd_re * signed'({1'b0, c_q});
      pr_im_q <= rd_im * signed'({1'b0, c_q});
    end
    if (state_q == ST_RD2 && (!m_valid_q || m_axis_tready_i)) begin
      m_data_q <= {6'd0, bin_q, sat_out(pr_im_q), sat_out(pr_re_q)};
      m_last_q <= last_q;
    end
    if (state_q == ST_IDLE && s_acc && s_axis_tuser_i == FuncRead && rdy_q) begin
      bin_q  <= rd_cnt_q[AddrBits-1:0];
      last_q <= (rd_cnt_q >= n_m1);
      c_q    <= scale_of(eff_l);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= 4'd10;
      negexp_q   <= 1'b0;
      load_cnt_q <= '0;
      rd_cnt_q   <= '0;
      rdy_q      <= 1'b0;
      state_q    <= ST_IDLE;
      ph_q       <= '0;
      cnt_q      <= '0;
      stage_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgSizeLog2: size_q   <= cfg_wdata_i;
          CfgNegExp:   negexp_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      // the read path refills the output register itself
      if (m_valid_q && m_axis_tready_i && state_q != ST_RD2) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser_i == FuncLoad) begin
              rdy_q    <= 1'b0;
              rd_cnt_q <= '0;
              if (load_cnt_q >= n_m1) begin
                load_cnt_q <= '0;
                state_q    <= ST_REV;
                cnt_q      <= '0;
                ph_q       <= '0;
              end else begin
                load_cnt_q <= load_cnt_q + 11'd1;
              end
            end else if (rdy_q) begin
              if (rd_cnt_q >= n_m1) begin
                rdy_q    <= 1'b0;
                rd_cnt_q <= '0;
              end else begin
                rd_cnt_q <= rd_cnt_q + 11'd1;
              end
              state_q <= ST_RD1;
            end
          end
        end
        ST_REV: begin
          if ((ph_q == 3'd0 && rev_j > cnt_q) || ph_q == 3'd1 || ph_q == 3'd2) begin
            ph_q <= ph_q + 3'd1;
          end else begin
            ph_q <= '0;
            if (cnt_q == n_m1[AddrBits-1:0]) begin
              state_q <= ST_BFLY;
              cnt_q   <= '0;
              stage_q <= '0;
            end else begin
              cnt_q <= cnt_q + AddrBits'(1);
            end
          end
        end
        ST_BFLY: begin
          if (ph_q != 3'd6) begin
            ph_q <= ph_q + 3'd1;
          end else begin
            ph_q <= '0;
            if (cnt_q == n_m1[AddrBits:1]) begin
              cnt_q <= '0;
              if (stage_q == eff_l - 4'd1) begin
                state_q  <= ST_IDLE;
                rdy_q    <= 1'b1;
                rd_cnt_q <= '0;
              end else begin
                stage_q <= stage_q + 4'd1;
              end
            end else begin
              cnt_q <= cnt_q + AddrBits'(1);
            end
          end
        end
        ST_RD1: state_q <= ST_RD2;
        ST_RD2: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/cfft_chk.sv =====
// Port-level checks of the FFT core, bound to the top level.
`default_nettype none
module cfft_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);
  import cfft_pkg::*;

  // a stalled bin holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed under stall");

  // a new bin only comes out of the read path, which holds off the input
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("output word appeared without a read in flight");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == FuncLoad |=>
      !$rose(m_axis_tvalid_o))
    else $error("output word right after a load");

endmodule

bind complex_fft_radix2_unitary_core cfft_chk u_cfft_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
`default_nettype wire
